FILE: rtl/core/rcled_pkg.sv
package rcled_pkg;

    // Field widths
    localparam int CHANNEL_W  = 2;
    localparam int TIME_W     = 32;
    localparam int WIDTH_W    = 11;
    localparam int DUTY_W     = 8;
    localparam int HUE_W      = 9;
    localparam int NUM_CH     = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SWITCH_THRESHOLD = 2'd0,
        REG_BRIGHT_CUTOFF    = 2'd1
    } cfg_reg_t;

    typedef enum logic [CHANNEL_W-1:0] {
        CH_SWITCH = 2'd0,
        CH_BRIGHT = 2'd1,
        CH_HUE    = 2'd2
    } rc_channel_t;

    // Pulse width limits in microseconds
    localparam logic [WIDTH_W-1:0] W_MIN     = 11'd1000;
    localparam logic [WIDTH_W-1:0] W_MAX     = 11'd2000;
    localparam logic [WIDTH_W-1:0] W_DEFAULT = 11'd1500;

    localparam logic [WIDTH_W-1:0] SWITCH_THRESHOLD_RST = 11'd1500;
    localparam logic [DUTY_W-1:0]  BRIGHT_CUTOFF_RST    = 8'd20;

    // Divide by 1000 as multiply by reciprocal and shift; exact over the
    // product ranges used (brightness below 2^18, hue below 2^19)
    localparam int                 BRIGHT_SHIFT = 28;
    localparam logic [18:0]        BRIGHT_RECIP = 19'd268436;
    localparam int                 HUE_SHIFT    = 29;
    localparam logic [19:0]        HUE_RECIP    = 20'd536871;

    // Hue sector bounds in degrees
    localparam logic [HUE_W-1:0] DEG_60  = 9'd60;
    localparam logic [HUE_W-1:0] DEG_120 = 9'd120;
    localparam logic [HUE_W-1:0] DEG_180 = 9'd180;
    localparam logic [HUE_W-1:0] DEG_240 = 9'd240;
    localparam logic [HUE_W-1:0] DEG_300 = 9'd300;
    localparam logic [HUE_W-1:0] DEG_360 = 9'd360;

endpackage

FILE: rtl/core/rcled_evt_if.sv
interface rcled_evt_if;

    logic                            valid;
    logic                            ready;
    logic [rcled_pkg::CHANNEL_W-1:0] channel;
    logic                            level;
    logic [rcled_pkg::TIME_W-1:0]    time_us;

    modport source (output valid, output channel, output level, output time_us, input ready);
    modport sink   (input valid, input channel, input level, input time_us, output ready);

endinterface

FILE: rtl/core/rcled_led_if.sv
interface rcled_led_if;

    logic                         valid;
    logic                         ready;
    logic                         switch_led;
    logic [rcled_pkg::DUTY_W-1:0] bright_duty;
    logic [rcled_pkg::DUTY_W-1:0] red_duty;
    logic [rcled_pkg::DUTY_W-1:0] green_duty;
    logic [rcled_pkg::DUTY_W-1:0] blue_duty;
    logic                         width_updated;

    modport source (output valid, output switch_led, output bright_duty, output red_duty,
                    output green_duty, output blue_duty, output width_updated, input ready);
    modport sink   (input valid, input switch_led, input bright_duty, input red_duty,
                    input green_duty, input blue_duty, input width_updated, output ready);

endinterface

FILE: rtl/core/rcled_cfg_if.sv
interface rcled_cfg_if;

    logic                             valid;
    logic                             ready;
    logic [rcled_pkg::CFG_IDX_W-1:0]  idx;
    logic [rcled_pkg::CFG_DATA_W-1:0] wdata;

    modport source (output valid, output idx, output wdata, input ready);
    modport sink   (input valid, input idx, input wdata, output ready);

endinterface

FILE: rtl/core/rc_pulse_to_led_drive_unit.sv
// Channel | Dir | Payload                                            | Transaction when
// evt     | in  | channel, level, time_us                            | valid && ready
// led     | out | switch_led, bright_duty, red/green/blue_duty,      | valid && ready
//         |     | width_updated                                      |
// cfg     | in  | idx, wdata                                         | valid && ready
//
// One evt transaction per cycle unless led stalls; each yields one led transaction
// via the stage chain: edge capture, offset/scale, reciprocal multiply, color map.
// The per-channel edge state is updated at the accepting edge, so back-to-back
// events on one channel see each other. cfg is always ready.
// rst_n resets edge state (rise times 0, widths 1500), cfg registers and stage valids.
// A stall on led holds a stage only when it and every later stage are full.
module rc_pulse_to_led_drive_unit (
    input  logic              clk,
    input  logic              rst_n,
    rcled_evt_if.sink         evt,
    rcled_led_if.source       led,
    rcled_cfg_if.sink         cfg
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [rcled_pkg::WIDTH_W-1:0] switch_threshold_reg;
    logic [rcled_pkg::DUTY_W-1:0]  bright_cutoff_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            switch_threshold_reg <= rcled_pkg::SWITCH_THRESHOLD_RST;
            bright_cutoff_reg    <= rcled_pkg::BRIGHT_CUTOFF_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.idx)
                rcled_pkg::REG_SWITCH_THRESHOLD:
                    switch_threshold_reg <= cfg.wdata;
                rcled_pkg::REG_BRIGHT_CUTOFF:
                    bright_cutoff_reg <= cfg.wdata[rcled_pkg::DUTY_W-1:0];
                default:
                    ; // drop writes to unused indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: a stage advances when it is empty or its successor
    // advances.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic out_adv, s3_adv, s2_adv, s1_adv;
    logic evt_accept;

    assign out_adv    = !out_valid_reg || led.ready;
    assign s3_adv     = !s3_valid_reg || out_adv;
    assign s2_adv     = !s2_valid_reg || s3_adv;
    assign s1_adv     = !s1_valid_reg || s2_adv;
    assign evt.ready  = s1_adv;
    assign evt_accept = evt.valid && s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_valid_reg <= evt.valid;
            if (s2_adv)
                s2_valid_reg <= s1_valid_reg;
            if (s3_adv)
                s3_valid_reg <= s2_valid_reg;
            if (out_adv)
                out_valid_reg <= s3_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Edge state: rise time and last width per channel. A falling edge
    // measures the wrapped difference; out of range widths fall back to
    // the default. The channel code past hue leaves the state alone.
    // ------------------------------------------------------------------
    logic [rcled_pkg::TIME_W-1:0]  rise_time_reg   [rcled_pkg::NUM_CH];
    logic [rcled_pkg::TIME_W-1:0]  rise_time_next  [rcled_pkg::NUM_CH];
    logic [rcled_pkg::WIDTH_W-1:0] pulse_width_reg [rcled_pkg::NUM_CH];
    logic [rcled_pkg::WIDTH_W-1:0] pulse_width_next[rcled_pkg::NUM_CH];
    logic [rcled_pkg::TIME_W-1:0]  delta_us        [rcled_pkg::NUM_CH];
    logic                          width_upd;

    always_comb
    begin
        width_upd = evt_accept && !evt.level &&
                    (evt.channel == rcled_pkg::CH_SWITCH ||
                     evt.channel == rcled_pkg::CH_BRIGHT ||
                     evt.channel == rcled_pkg::CH_HUE);
        for (int i = 0; i < rcled_pkg::NUM_CH; i++)
        begin
            delta_us[i]         = evt.time_us - rise_time_reg[i];
            rise_time_next[i]   = rise_time_reg[i];
            pulse_width_next[i] = pulse_width_reg[i];
            if (evt_accept && evt.channel == rcled_pkg::CHANNEL_W'(i))
            begin
                if (evt.level)
                    rise_time_next[i] = evt.time_us;
                else if (delta_us[i] >= rcled_pkg::TIME_W'(rcled_pkg::W_MIN) &&
                         delta_us[i] <= rcled_pkg::TIME_W'(rcled_pkg::W_MAX))
                    pulse_width_next[i] = delta_us[i][rcled_pkg::WIDTH_W-1:0];
                else
                    pulse_width_next[i] = rcled_pkg::W_DEFAULT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rcled_pkg::NUM_CH; i++)
            begin
                rise_time_reg[i]   <= '0;
                pulse_width_reg[i] <= rcled_pkg::W_DEFAULT;
            end
        end
        else
        begin
            for (int i = 0; i < rcled_pkg::NUM_CH; i++)
            begin
                rise_time_reg[i]   <= rise_time_next[i];
                pulse_width_reg[i] <= pulse_width_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: snapshot of all widths after this event
    // ------------------------------------------------------------------
    logic [rcled_pkg::WIDTH_W-1:0] s1_sw_width_reg;
    logic [rcled_pkg::WIDTH_W-1:0] s1_br_width_reg;
    logic [rcled_pkg::WIDTH_W-1:0] s1_hue_width_reg;
    logic                          s1_upd_reg;

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_sw_width_reg  <= pulse_width_next[rcled_pkg::CH_SWITCH];
            s1_br_width_reg  <= pulse_width_next[rcled_pkg::CH_BRIGHT];
            s1_hue_width_reg <= pulse_width_next[rcled_pkg::CH_HUE];
            s1_upd_reg       <= width_upd;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: remove the 1000 us offset and scale by 255 and by 360
    // with shift-adds
    // ------------------------------------------------------------------
    logic [9:0]  br_off, hue_off;
    logic [17:0] br_scaled;
    logic [18:0] hue_scaled;

    logic [rcled_pkg::WIDTH_W-1:0] s2_sw_width_reg;
    logic [17:0]                   s2_br_scaled_reg;
    logic [18:0]                   s2_hue_scaled_reg;
    logic                          s2_upd_reg;

    always_comb
    begin
        br_off     = 10'(s1_br_width_reg - rcled_pkg::W_MIN);
        hue_off    = 10'(s1_hue_width_reg - rcled_pkg::W_MIN);
        // x*255 = x*256 - x
        br_scaled  = {br_off, 8'b0} - 18'(br_off);
        // x*360 = x*(256 + 64 + 32 + 8)
        hue_scaled = {1'b0, hue_off, 8'b0} + 19'({hue_off, 6'b0})
                   + 19'({hue_off, 5'b0}) + 19'({hue_off, 3'b0});
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            s2_sw_width_reg   <= s1_sw_width_reg;
            s2_br_scaled_reg  <= br_scaled;
            s2_hue_scaled_reg <= hue_scaled;
            s2_upd_reg        <= s1_upd_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: divide by 1000 through reciprocal multiply
    // ------------------------------------------------------------------
    logic [36:0] br_prod;
    logic [38:0] hue_prod;

    logic [rcled_pkg::WIDTH_W-1:0] s3_sw_width_reg;
    logic [rcled_pkg::DUTY_W-1:0]  s3_bright_reg;
    logic [rcled_pkg::HUE_W-1:0]   s3_hue_reg;
    logic                          s3_upd_reg;

    assign br_prod  = 37'(s2_br_scaled_reg) * 37'(rcled_pkg::BRIGHT_RECIP);
    assign hue_prod = 39'(s2_hue_scaled_reg) * 39'(rcled_pkg::HUE_RECIP);

    always_ff @(posedge clk)
    begin
        if (s3_adv)
        begin
            s3_sw_width_reg <= s2_sw_width_reg;
            s3_bright_reg   <= br_prod[rcled_pkg::BRIGHT_SHIFT +: rcled_pkg::DUTY_W];
            s3_hue_reg      <= hue_prod[rcled_pkg::HUE_SHIFT +: rcled_pkg::HUE_W];
            s3_upd_reg      <= s2_upd_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: switch compare, brightness cutoff, hue to inverted RGB.
    // Ramp x = floor(255*v/60) = floor(17*v/4), v = 60 - |h mod 120 - 60|.
    // Hue of 360 takes the last sector.
    // ------------------------------------------------------------------
    logic [rcled_pkg::HUE_W-1:0]  hue_mod;
    logic [5:0]                   ramp_dist;
    logic [5:0]                   ramp_v;
    logic [9:0]                   ramp_x17;
    logic [rcled_pkg::DUTY_W-1:0] ramp_x;
    logic [rcled_pkg::DUTY_W-1:0] red_next, green_next, blue_next, bright_next;
    logic                         switch_next;

    always_comb
    begin
        if (s3_hue_reg < rcled_pkg::DEG_120)
            hue_mod = s3_hue_reg;
        else if (s3_hue_reg < rcled_pkg::DEG_240)
            hue_mod = s3_hue_reg - rcled_pkg::DEG_120;
        else if (s3_hue_reg < rcled_pkg::DEG_360)
            hue_mod = s3_hue_reg - rcled_pkg::DEG_240;
        else
            hue_mod = '0;

        if (hue_mod >= rcled_pkg::DEG_60)
            ramp_dist = 6'(hue_mod - rcled_pkg::DEG_60);
        else
            ramp_dist = 6'(rcled_pkg::DEG_60 - hue_mod);
        ramp_v   = 6'(rcled_pkg::DEG_60) - ramp_dist;
        ramp_x17 = {ramp_v, 4'b0} + 10'(ramp_v);
        ramp_x   = ramp_x17[9:2];

        // Duties are 255 minus level: full level gives 0, zero gives 255
        if (s3_hue_reg < rcled_pkg::DEG_60)
        begin
            red_next = '0;      green_next = ~ramp_x; blue_next = '1;
        end
        else if (s3_hue_reg < rcled_pkg::DEG_120)
        begin
            red_next = ~ramp_x; green_next = '0;      blue_next = '1;
        end
        else if (s3_hue_reg < rcled_pkg::DEG_180)
        begin
            red_next = '1;      green_next = '0;      blue_next = ~ramp_x;
        end
        else if (s3_hue_reg < rcled_pkg::DEG_240)
        begin
            red_next = '1;      green_next = ~ramp_x; blue_next = '0;
        end
        else if (s3_hue_reg < rcled_pkg::DEG_300)
        begin
            red_next = ~ramp_x; green_next = '1;      blue_next = '0;
        end
        else
        begin
            red_next = '0;      green_next = '1;      blue_next = ~ramp_x;
        end

        bright_next = (s3_bright_reg <= bright_cutoff_reg) ? '0 : s3_bright_reg;
        switch_next = s3_sw_width_reg > switch_threshold_reg;
    end

    logic                         switch_led_reg;
    logic [rcled_pkg::DUTY_W-1:0] bright_duty_reg;
    logic [rcled_pkg::DUTY_W-1:0] red_duty_reg;
    logic [rcled_pkg::DUTY_W-1:0] green_duty_reg;
    logic [rcled_pkg::DUTY_W-1:0] blue_duty_reg;
    logic                         width_updated_reg;

    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            switch_led_reg    <= switch_next;
            bright_duty_reg   <= bright_next;
            red_duty_reg      <= red_next;
            green_duty_reg    <= green_next;
            blue_duty_reg     <= blue_next;
            width_updated_reg <= s3_upd_reg;
        end
    end

    assign led.valid         = out_valid_reg;
    assign led.switch_led    = switch_led_reg;
    assign led.bright_duty   = bright_duty_reg;
    assign led.red_duty      = red_duty_reg;
    assign led.green_duty    = green_duty_reg;
    assign led.blue_duty     = blue_duty_reg;
    assign led.width_updated = width_updated_reg;

`ifndef SYNTH
    // Stored widths never leave the legal pulse range
    a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
        pulse_width_reg[0] >= rcled_pkg::W_MIN && pulse_width_reg[0] <= rcled_pkg::W_MAX &&
        pulse_width_reg[1] >= rcled_pkg::W_MIN && pulse_width_reg[1] <= rcled_pkg::W_MAX &&
        pulse_width_reg[2] >= rcled_pkg::W_MIN && pulse_width_reg[2] <= rcled_pkg::W_MAX)
        else $error("pulse width out of range");

    // A rising edge transaction never touches the widths
    a_rise_keeps_width: assert property (@(posedge clk) disable iff (!rst_n)
        evt_accept && evt.level |=>
            $stable(pulse_width_reg[0]) && $stable(pulse_width_reg[1]) &&
            $stable(pulse_width_reg[2]))
        else $error("rising edge changed a width");

    // Reciprocal divide keeps hue within one turn
    a_hue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> s3_hue_reg <= rcled_pkg::DEG_360)
        else $error("hue above 360 degrees");
`endif

endmodule

FILE: dv/tb_rc_pulse_to_led_drive_unit.sv
`timescale 1ns / 100ps

module tb_rc_pulse_to_led_drive_unit;
    import rcled_pkg::*;

    // Chance in percent that a side idles in a given cycle
    localparam int IDLE_PCT    = 28;
    // Event to LED transaction latency given by the stage chain
    localparam int LED_LATENCY = 4;
    // Far above the slowest legal run of about 1250 events
    localparam int CYCLE_LIMIT = 200000;

    // The unused fourth channel code and the two spare register indexes
    localparam logic [CHANNEL_W-1:0] CH_SPARE    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam logic                 LVL_RISE    = 1'b1;
    localparam logic                 LVL_FALL    = 1'b0;

    typedef struct packed {
        logic              switch_led;
        logic [DUTY_W-1:0] bright_duty;
        logic [DUTY_W-1:0] red_duty;
        logic [DUTY_W-1:0] green_duty;
        logic [DUTY_W-1:0] blue_duty;
        logic              width_updated;
    } led_word_t;

    logic clk;
    logic rst_n;

    rcled_evt_if evt();
    rcled_led_if led();
    rcled_cfg_if cfg();

    rc_pulse_to_led_drive_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt),
        .led   (led),
        .cfg   (cfg)
    );

    // Shadow of the decoder: edge times, stored widths and both registers
    logic [TIME_W-1:0]  rise_stamp [NUM_CH];
    logic [WIDTH_W-1:0] width_us   [NUM_CH];
    logic [WIDTH_W-1:0] thr_us;
    logic [DUTY_W-1:0]  cutoff_duty;

    // LED words still owed by the block, oldest first
    led_word_t expected_leds [$];

    bit          steady_flow = 1'b0;
    logic [31:0] now_us;
    int          events_sent  = 0;
    int          leds_checked = 0;
    int          reg_writes   = 0;
    int          mismatches   = 0;
    int          cycle_count  = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: a hung handshake or a lost LED transaction ends the run here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d LED transactions pending",
                   cycle_count, expected_leds.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Apply one edge event to the shadow state and return the LED word it yields.
    function automatic led_word_t predict_led(input logic [CHANNEL_W-1:0] ch,
                                              input logic lv,
                                              input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] span;
        int unsigned       excess;
        int unsigned       duty;
        int unsigned       hue;
        int unsigned       fold;
        int unsigned       gap;
        logic [7:0]        ramp;
        logic [7:0]        r;
        logic [7:0]        g;
        logic [7:0]        b;
        led_word_t         word;

        word.width_updated = 1'b0;
        // The spare channel touches no state but still produces a word
        if (ch != CH_SPARE)
        begin
            if (lv == LVL_RISE)
                rise_stamp[ch] = t;
            else
            begin
                // Wrapping difference; anything outside the servo range reads as center
                span = t - rise_stamp[ch];
                width_us[ch] = (span >= W_MIN && span <= W_MAX) ? span[WIDTH_W-1:0]
                                                                : W_DEFAULT;
                word.width_updated = 1'b1;
            end
        end

        word.switch_led = (width_us[CH_SWITCH] > thr_us);

        excess = width_us[CH_BRIGHT] - W_MIN;
        duty   = (excess * 255) / 1000;
        word.bright_duty = (duty <= cutoff_duty) ? 8'd0 : 8'(duty);

        // Hue in degrees, then the triangle ramp that peaks at odd multiples of 60
        excess = width_us[CH_HUE] - W_MIN;
        hue    = (excess * 360) / 1000;
        fold   = hue % 120;
        gap    = (fold >= 60) ? fold - 60 : 60 - fold;
        ramp   = 8'((255 * (60 - gap)) / 60);

        // 360 degrees stays in the last sector
        if (hue < DEG_60)
            {r, g, b} = {8'd255, ramp, 8'd0};
        else if (hue < DEG_120)
            {r, g, b} = {ramp, 8'd255, 8'd0};
        else if (hue < DEG_180)
            {r, g, b} = {8'd0, 8'd255, ramp};
        else if (hue < DEG_240)
            {r, g, b} = {8'd0, ramp, 8'd255};
        else if (hue < DEG_300)
            {r, g, b} = {ramp, 8'd0, 8'd255};
        else
            {r, g, b} = {8'd255, 8'd0, ramp};

        // Common-anode LEDs: the duty is the complement of the level
        word.red_duty   = 8'd255 - r;
        word.green_duty = 8'd255 - g;
        word.blue_duty  = 8'd255 - b;
        return word;
    endfunction

    // Track register writes and accepted events at the edge that moves them.
    always @(posedge clk)
    begin
        if (rst_n && cfg.valid && cfg.ready)
        begin
            reg_writes++;
            if (cfg.idx == REG_SWITCH_THRESHOLD)
                thr_us = cfg.wdata;
            else if (cfg.idx == REG_BRIGHT_CUTOFF)
                cutoff_duty = cfg.wdata[DUTY_W-1:0];
        end
        if (rst_n && evt.valid && evt.ready)
            expected_leds.push_back(predict_led(evt.channel, evt.level, evt.time_us));
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Compare every LED transaction against the oldest outstanding prediction.
    always @(posedge clk)
    begin
        led_word_t want;
        if (rst_n && led.valid && led.ready)
        begin
            leds_checked++;
            if (expected_leds.size() == 0)
            begin
                $error("LED transaction with no event outstanding");
                mismatches++;
            end
            else
            begin
                want = expected_leds.pop_front();
                check_field("switch_led",    want.switch_led,    led.switch_led);
                check_field("bright_duty",   want.bright_duty,   led.bright_duty);
                check_field("red_duty",      want.red_duty,      led.red_duty);
                check_field("green_duty",    want.green_duty,    led.green_duty);
                check_field("blue_duty",     want.blue_duty,     led.blue_duty);
                check_field("width_updated", want.width_updated, led.width_updated);
            end
        end
    end

    // Stall the LED side at random, except during the steady stretch.
    always @(negedge clk)
        led.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);

    // Offer one event and hold it until the transaction. Valid stays high on
    // return so that a following event can go out in the next cycle.
    task automatic send_event(input logic [CHANNEL_W-1:0] ch, input logic lv,
                              input logic [TIME_W-1:0] t);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT)
        begin
            evt.valid <= 1'b0;
            @(negedge clk);
        end
        evt.valid   <= 1'b1;
        evt.channel <= ch;
        evt.level   <= lv;
        evt.time_us <= t;
        @(posedge clk);
        while (!evt.ready)
            @(posedge clk);
        events_sent++;
        @(negedge clk);
    endtask

    task automatic send_pulse(input logic [CHANNEL_W-1:0] ch, input logic [TIME_W-1:0] start,
                              input logic [TIME_W-1:0] span);
        send_event(ch, LVL_RISE, start);
        send_event(ch, LVL_FALL, start + span);
    endtask

    // Drop valid and hold until every LED transaction owed has come back.
    task automatic settle();
        evt.valid <= 1'b0;
        while (expected_leds.size() != 0)
            @(negedge clk);
    endtask

    // Write one register; cfg valid stays high for a following write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.idx   <= idx;
        cfg.wdata <= data;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Write both registers, plus junk to a spare index that must be ignored.
    task automatic program_regs(input logic [CFG_DATA_W-1:0] thr_data,
                                input logic [CFG_DATA_W-1:0] cut_data);
        write_reg(REG_SWITCH_THRESHOLD, thr_data);
        write_reg(REG_BRIGHT_CUTOFF, cut_data);
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, CFG_DATA_W'($urandom));
        cfg.valid <= 1'b0;
    endtask

    // Mostly servo-range widths, some hugging the limits, some wild.
    function automatic logic [TIME_W-1:0] pick_width();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1000, 2000);
        else if (roll < 85)
            return $urandom_range(0, 1) ? $urandom_range(990, 1010) : $urandom_range(1990, 2010);
        else
            return $urandom;
    endfunction

    // Random traffic: well-formed pulses, overlapping pulses on two channels,
    // and a share of stray edges on any channel code with any timestamp.
    task automatic random_traffic(input int count);
        int                   goal;
        int unsigned          roll;
        logic [CHANNEL_W-1:0] ch_a;
        logic [CHANNEL_W-1:0] ch_b;
        logic [TIME_W-1:0]    lag;
        logic [TIME_W-1:0]    span_a;
        logic [TIME_W-1:0]    span_b;

        goal = events_sent + count;
        while (events_sent < goal)
        begin
            roll = $urandom_range(0, 99);
            ch_a = CHANNEL_W'($urandom_range(0, 2));
            now_us += $urandom_range(0, 30000);
            if (roll < 55)
            begin
                span_a = pick_width();
                send_pulse(ch_a, now_us, span_a);
                now_us += span_a;
            end
            else if (roll < 80)
            begin
                ch_b   = CHANNEL_W'((ch_a + $urandom_range(1, 2)) % 3);
                lag    = $urandom_range(0, 3000);
                span_a = pick_width();
                span_b = pick_width();
                send_event(ch_a, LVL_RISE, now_us);
                send_event(ch_b, LVL_RISE, now_us + lag);
                send_event(ch_a, LVL_FALL, now_us + span_a);
                send_event(ch_b, LVL_FALL, now_us + lag + span_b);
                now_us += lag + 4000;
            end
            else
                send_event(CHANNEL_W'($urandom_range(0, 3)), 1'($urandom), $urandom);
        end
    endtask

    // Reset state, boundary widths on every channel, timestamp wrap and the
    // spare channel, all under the reset register values.
    task automatic test_directed_edges();
        // Spare channel leaves the defaults in place
        send_event(CH_SPARE, LVL_RISE, 32'h1234_5678);
        send_event(CH_SPARE, LVL_FALL, 32'hFFFF_FFFF);
        // Falling edge with no rise since reset measures from time zero
        send_event(CH_HUE, LVL_FALL, 32'd1700);
        // Rise before the timestamp wraps, fall after it
        send_pulse(CH_SWITCH, 32'hFFFF_FE00, 32'd1280);
        // Just above the reset threshold
        send_pulse(CH_SWITCH, 32'd5000, 32'd1501);
        // Largest timestamp, shortest legal width, then a second fall on the same rise
        send_pulse(CH_SWITCH, 32'hFFFF_FFFF, 32'd1000);
        send_event(CH_SWITCH, LVL_FALL, 32'h0000_07CF);
        // Brightness: both ends of the range and both out-of-range neighbors
        send_pulse(CH_BRIGHT, 32'd10000, 32'd1000);
        send_pulse(CH_BRIGHT, 32'd20000, 32'd2000);
        send_pulse(CH_BRIGHT, 32'd30000, 32'd999);
        send_pulse(CH_BRIGHT, 32'd40000, 32'd2001);
        // Hue at 0 degrees, at 360 degrees, and just below the first sector edge
        send_pulse(CH_HUE, 32'd50000, 32'd1000);
        send_pulse(CH_HUE, 32'd60000, 32'd2000);
        send_pulse(CH_HUE, 32'd70000, 32'd1166);
    endtask

    // Walk both registers through their extremes, with traffic under each setting.
    task automatic test_register_sweep();
        logic [CFG_DATA_W-1:0] thr_pick [5] = '{11'd0, 11'h7FF, 11'd1000, 11'd2000, 11'd1500};
        logic [CFG_DATA_W-1:0] cut_pick [5] = '{11'h000, 11'h7FF, 11'd255, 11'd20, 11'h4A5};

        for (int i = 0; i < 6; i++)
        begin
            settle();
            if (i < 5)
                program_regs(thr_pick[i], cut_pick[i]);
            else
                program_regs(CFG_DATA_W'($urandom_range(1000, 2000)),
                             CFG_DATA_W'($urandom_range(0, 255)));
            random_traffic(100);
        end
    endtask

    // Long random run starting just below the timestamp wrap.
    task automatic test_random_traffic();
        now_us = 32'hFFFF_FFFF - $urandom_range(0, 2000000);
        random_traffic(420);
    endtask

    // Both sides at full rate: events back to back, LED side never stalled.
    task automatic test_back_to_back();
        steady_flow = 1'b1;
        random_traffic(200);
        steady_flow = 1'b0;
    endtask

    initial
    begin
        evt.valid   = 1'b0;
        evt.channel = CH_SWITCH;
        evt.level   = LVL_FALL;
        evt.time_us = '0;
        cfg.valid   = 1'b0;
        cfg.idx     = REG_SWITCH_THRESHOLD;
        cfg.wdata   = '0;
        led.ready   = 1'b0;
        rst_n       = 1'b0;

        for (int i = 0; i < NUM_CH; i++)
        begin
            rise_stamp[i] = '0;
            width_us[i]   = W_DEFAULT;
        end
        thr_us      = SWITCH_THRESHOLD_RST;
        cutoff_duty = BRIGHT_CUTOFF_RST;
        now_us      = $urandom;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_edges();
        test_register_sweep();
        test_random_traffic();
        test_back_to_back();

        // Drain, then give the pipeline time to show any stray transaction
        settle();
        repeat (LED_LATENCY + 4) @(negedge clk);
        if (expected_leds.size() != 0)
        begin
            $error("%0d LED transactions never arrived", expected_leds.size());
            mismatches += expected_leds.size();
        end

        $display("Ran %0d edge events over all channel codes, %0d LED words compared,",
                 events_sent, leds_checked);
        $display("%0d register writes across threshold and cutoff extremes, %0d mismatches",
                 reg_writes, mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/rcled_pkg.sv
rtl/core/rcled_evt_if.sv
rtl/core/rcled_led_if.sv
rtl/core/rcled_cfg_if.sv
rtl/core/rc_pulse_to_led_drive_unit.sv
dv/tb_rc_pulse_to_led_drive_unit.sv
